### rtl/core/lsae_pkg.sv
// ---------------------------------------------------------------------------
// lsae_pkg
// shared constants, action and mode codes, and colour helpers for the
// led strip animation engine
// ---------------------------------------------------------------------------
package lsae_pkg;

  localparam int LSAE_PIXELS = 16;

  localparam int COLOUR_W = 24;

  localparam logic [2:0] ACT_SET_PIXEL = 3'd0;
  localparam logic [2:0] ACT_SET_ALL   = 3'd1;
  localparam logic [2:0] ACT_SET_MODE  = 3'd2;
  localparam logic [2:0] ACT_RENDER    = 3'd3;
  localparam logic [2:0] ACT_SHOW      = 3'd4;

  localparam logic [2:0] MODE_OFF      = 3'd0;
  localparam logic [2:0] MODE_BREATH   = 3'd1;
  localparam logic [2:0] MODE_FLOW     = 3'd2;
  localparam logic [2:0] MODE_GRADIENT = 3'd3;
  localparam logic [2:0] MODE_COLORFUL = 3'd4;
  localparam logic [2:0] MODE_LIMIT    = 3'd5;

  localparam logic [7:0] BREATH_PERIOD = 8'd200;
  localparam logic [7:0] BREATH_HALF   = 8'd100;
  localparam logic [7:0] HUE_STEP_GRAD = 8'd2;
  localparam logic [7:0] HUE_STEP_RBOW = 8'd3;
  localparam logic [7:0] HUE_PIX_STEP  = 8'd10;

  localparam logic [27:0] BREATH_RECIP = 28'd5243;

  typedef logic [COLOUR_W-1:0] colour_t;

  function automatic colour_t pack_grb(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    return {g, r, b};
  endfunction

  // 255 * scale / 100 for scale up to 100, by reciprocal multiplication
  function automatic logic [7:0] breath_level(input logic [6:0] scale);
    logic [14:0] x;
    logic [27:0] prod;
    x = {scale, 8'd0} - 15'(scale);
    prod = 28'(x) * BREATH_RECIP;
    return prod[26:19];
  endfunction

  function automatic colour_t hue_word(input logic [7:0] h);
    logic [2:0] region;
    logic [7:0] start;
    logic [5:0] d;
    logic [7:0] rem;
    logic [7:0] q;
    if (h >= 8'd215) begin
      region = 3'd5;
      start  = 8'd215;
    end else if (h >= 8'd172) begin
      region = 3'd4;
      start  = 8'd172;
    end else if (h >= 8'd129) begin
      region = 3'd3;
      start  = 8'd129;
    end else if (h >= 8'd86) begin
      region = 3'd2;
      start  = 8'd86;
    end else if (h >= 8'd43) begin
      region = 3'd1;
      start  = 8'd43;
    end else begin
      region = 3'd0;
      start  = 8'd0;
    end
    d   = 6'(h - start);
    rem = {d, 2'b00} + {1'b0, d, 1'b0};
    q   = 8'd255 - rem;
    unique case (region)
      3'd0:    return pack_grb(8'd255, rem, 8'd0);
      3'd1:    return pack_grb(q, 8'd255, 8'd0);
      3'd2:    return pack_grb(8'd0, 8'd255, rem);
      3'd3:    return pack_grb(8'd0, q, 8'd255);
      3'd4:    return pack_grb(rem, 8'd0, 8'd255);
      default: return pack_grb(8'd255, 8'd0, q);
    endcase
  endfunction

endpackage

### rtl/core/lsae_ram.sv
// ---------------------------------------------------------------------------
// lsae_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module lsae_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/led_strip_animation_engine.sv
// set pixel, set all and set mode are handled in the cycle they are accepted
// show and render walk the store: the transaction, a ram read to prime,
// then one pixel per cycle while the output is not stalled
// render in colorful mode first writes a hue into the ram for every pixel, one hue per cycle
// output stalls pause the pixel walk; a new transaction is taken once the walk ends
// reset is synchronous; per-pixel valid bits make the whole store read black at once
// ---------------------------------------------------------------------------
// led_strip_animation_engine
// grb colour store in a ram with animation render and strip-order pixel output
// ---------------------------------------------------------------------------
module led_strip_animation_engine
  import lsae_pkg::*;
#(
  parameter int PIXEL_COUNT = LSAE_PIXELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [15:0] pixel_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [2:0]  mode_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  led_number,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [7:0]  out_blue,
  output logic        last_pixel
);

  localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(PIXEL_COUNT - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FILL  = 2'd1;
  localparam logic [1:0] ST_PRIME = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]             state;
  logic [AW-1:0]          p;
  logic [7:0]             walk;
  colour_t                base;
  logic [PIXEL_COUNT-1:0] valid_bits;
  logic [2:0]             mode;
  logic [15:0]            frame_tick;
  logic [7:0]             breath_phase;
  logic [15:0]            dot_position;
  logic [AW-1:0]          dot_slot;
  logic [7:0]             hue_phase;

  logic          accept;
  logic          load;
  logic          last_p;
  logic          idx_ok;
  colour_t       pix_word;
  logic [6:0]    scale;
  logic [7:0]    breath_phase_next;
  logic [AW-1:0] dot_slot_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  colour_t       ram_wdata;
  logic [AW-1:0] ram_raddr;
  colour_t       ram_rdata;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = (state == ST_EMIT) && (!out_valid || out_ready);
  assign last_p   = (p == LAST_IDX);
  assign idx_ok   = (pixel_index < 16'(PIXEL_COUNT));
  assign pix_word = valid_bits[p] ? ram_rdata : base;
  assign scale    = (breath_phase <= BREATH_HALF) ? 7'(breath_phase)
                                                  : 7'(BREATH_PERIOD - breath_phase);

  assign breath_phase_next = ((frame_tick == 16'hFFFF) ||
                              (breath_phase == BREATH_PERIOD - 8'd1)) ? 8'd0
                                                                      : breath_phase + 8'd1;
  assign dot_slot_next = ((dot_position == 16'hFFFF) || (dot_slot == LAST_IDX)) ? '0
                                                                                : dot_slot + 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p;
    ram_wdata = hue_word(walk);
    if (state == ST_FILL) begin
      ram_we = 1'b1;
    end else if (accept && (action == ACT_SET_PIXEL) && idx_ok) begin
      ram_we    = 1'b1;
      ram_waddr = pixel_index[AW-1:0];
      ram_wdata = pack_grb(red, green, blue);
    end else if (accept && (action == ACT_RENDER) && (mode == MODE_FLOW)) begin
      ram_we    = 1'b1;
      ram_waddr = dot_slot;
      ram_wdata = {COLOUR_W{1'b1}};
    end
  end

  assign ram_raddr = (load && !last_p) ? p + 1'b1 : p;

  lsae_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (PIXEL_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      p            <= '0;
      base         <= '0;
      valid_bits   <= '0;
      mode         <= MODE_OFF;
      frame_tick   <= '0;
      breath_phase <= '0;
      dot_position <= '0;
      dot_slot     <= '0;
      hue_phase    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (action)
              ACT_SET_PIXEL: begin
                if (idx_ok) begin
                  valid_bits[pixel_index[AW-1:0]] <= 1'b1;
                end
              end
              ACT_SET_ALL: begin
                base       <= pack_grb(red, green, blue);
                valid_bits <= '0;
              end
              ACT_SET_MODE: begin
                if (mode_value < MODE_LIMIT) begin
                  mode         <= mode_value;
                  frame_tick   <= '0;
                  breath_phase <= '0;
                  dot_position <= '0;
                  dot_slot     <= '0;
                  hue_phase    <= '0;
                end
              end
              ACT_RENDER: begin
                frame_tick   <= frame_tick + 16'd1;
                breath_phase <= breath_phase_next;
                p            <= '0;
                state        <= ST_PRIME;
                case (mode)
                  MODE_BREATH: begin
                    base       <= pack_grb(8'd0, 8'd0, breath_level(scale));
                    valid_bits <= '0;
                  end
                  MODE_FLOW: begin
                    base         <= '0;
                    valid_bits   <= PIXEL_COUNT'(1'b1) << dot_slot;
                    dot_position <= dot_position + 16'd1;
                    dot_slot     <= dot_slot_next;
                  end
                  MODE_GRADIENT: begin
                    base       <= hue_word(hue_phase);
                    valid_bits <= '0;
                    hue_phase  <= hue_phase + HUE_STEP_GRAD;
                  end
                  MODE_COLORFUL: begin
                    walk      <= hue_phase;
                    hue_phase <= hue_phase + HUE_STEP_RBOW;
                    state     <= ST_FILL;
                  end
                  default: begin
                    base       <= '0;
                    valid_bits <= '0;
                  end
                endcase
              end
              ACT_SHOW: begin
                p     <= '0;
                state <= ST_PRIME;
              end
              default: ;
            endcase
          end
        end
        ST_FILL: begin
          valid_bits[p] <= 1'b1;
          walk          <= walk + HUE_PIX_STEP;
          if (last_p) begin
            p     <= '0;
            state <= ST_PRIME;
          end else begin
            p <= p + 1'b1;
          end
        end
        ST_PRIME: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load) begin
            if (last_p) begin
              state <= ST_IDLE;
            end else begin
              p <= p + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      led_number <= 6'(p);
      out_green  <= pix_word[23:16];
      out_red    <= pix_word[15:8];
      out_blue   <= pix_word[7:0];
      last_pixel <= last_p;
    end
  end

  a_fill_writes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> ram_we)
    else $error("colour fill cycle without ram write");

  a_last_number: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_pixel) |-> (led_number == 6'(PIXEL_COUNT - 1)))
    else $error("last pixel flag on wrong led number");

  a_show_primes: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == ACT_SHOW)) |=> (state == ST_PRIME))
    else $error("show transaction did not start a pixel walk");

  a_walk_step: assert property (@(posedge clk) disable iff (rst)
    (load && !last_p) |=> (p == AW'($past(p) + 1'b1)))
    else $error("pixel walk skipped or repeated a pixel");

endmodule

### verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the led strip animation engine: random input
// bursts, a stalling receiver with one long hold-off, and an in-bench model
// of the colour store and animation counters
// ---------------------------------------------------------------------------
module tb_top
  import lsae_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPIX         = LSAE_PIXELS;
  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLDOFF_LEN  = 300;
  localparam int RANDOM_ITEMS = 20;

  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  localparam logic [2:0] MODE_TOP      = 3'd7;

  typedef struct packed {
    logic [5:0] led;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] b;
    logic       last;
  } pixel_t;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_BURSTY} rx_style_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  action = '0;
  logic [15:0] pixel_index = '0;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;
  logic [2:0]  mode_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  led_number;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic [7:0]  out_blue;
  logic        last_pixel;

  // model state
  colour_t     led_store [NPIX];
  logic [2:0]  anim_mode = MODE_OFF;
  logic [15:0] anim_tick = '0;
  logic [15:0] dot_pos = '0;
  logic [7:0]  hue_pos = '0;

  pixel_t      expected_pixels [$];
  pixel_t      want;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  // receiver pattern
  logic        start_holdoff = 1'b0;
  int          holdoff_left = 0;
  rx_style_e   rx_style = RX_STEADY;
  int          style_left = 0;
  int          stall_run = 0;

  led_strip_animation_engine dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .pixel_index(pixel_index),
    .red(red),
    .green(green),
    .blue(blue),
    .mode_value(mode_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .led_number(led_number),
    .out_green(out_green),
    .out_red(out_red),
    .out_blue(out_blue),
    .last_pixel(last_pixel)
  );

  always #1 clk = ~clk;

  function automatic colour_t hue_colour(input logic [7:0] h);
    int unsigned sector;
    logic [7:0]  up;
    logic [7:0]  down;
    sector = h / 43;
    up     = 8'((h - sector * 43) * 6);
    down   = 8'd255 - up;
    case (sector)
      0:       return {up, 8'd255, 8'd0};
      1:       return {8'd255, down, 8'd0};
      2:       return {8'd255, 8'd0, up};
      3:       return {down, 8'd0, 8'd255};
      4:       return {8'd0, up, 8'd255};
      default: return {8'd0, 8'd255, down};
    endcase
  endfunction

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_frame();
    pixel_t px;
    for (int i = 0; i < NPIX; i++) begin
      px.led  = 6'(i);
      px.g    = led_store[i][23:16];
      px.r    = led_store[i][15:8];
      px.b    = led_store[i][7:0];
      px.last = (i == NPIX - 1);
      expected_pixels.push_back(px);
    end
  endtask

  task automatic model_strip(input logic [2:0] act, input logic [15:0] idx,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [2:0] md);
    int unsigned phase;
    int unsigned scale;
    case (act)
      ACT_SET_PIXEL: begin
        if (idx < NPIX) led_store[idx] = {g, r, b};
      end
      ACT_SET_ALL: begin
        foreach (led_store[i]) led_store[i] = {g, r, b};
      end
      ACT_SET_MODE: begin
        if (md < MODE_LIMIT) begin
          anim_mode = md;
          anim_tick = '0;
          dot_pos   = '0;
          hue_pos   = '0;
        end
      end
      ACT_RENDER: begin
        case (anim_mode)
          MODE_BREATH: begin
            phase = anim_tick % BREATH_PERIOD;
            scale = (phase <= BREATH_HALF) ? phase : BREATH_PERIOD - phase;
            foreach (led_store[i]) led_store[i] = {16'd0, 8'((255 * scale) / 100)};
          end
          MODE_FLOW: begin
            foreach (led_store[i]) led_store[i] = '0;
            led_store[dot_pos % NPIX] = 24'hFFFFFF;
            dot_pos = dot_pos + 16'd1;
          end
          MODE_GRADIENT: begin
            foreach (led_store[i]) led_store[i] = hue_colour(hue_pos);
            hue_pos = hue_pos + HUE_STEP_GRAD;
          end
          MODE_COLORFUL: begin
            foreach (led_store[i]) led_store[i] = hue_colour(8'(hue_pos + i * HUE_PIX_STEP));
            hue_pos = hue_pos + HUE_STEP_RBOW;
          end
          default: begin
            foreach (led_store[i]) led_store[i] = '0;
          end
        endcase
        anim_tick = anim_tick + 16'd1;
        queue_frame();
      end
      ACT_SHOW: begin
        queue_frame();
      end
      default: ;
    endcase
  endtask

  // one transaction on the input side, with a gap in front of it when a new burst starts
  task automatic send_action(input logic [2:0] act, input logic [15:0] idx,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [2:0] md);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = $urandom_range(1, 10);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    action      <= act;
    pixel_index <= idx;
    red         <= r;
    green       <= g;
    blue        <= b;
    mode_value  <= md;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    model_strip(act, idx, r, g, b, md);
  endtask

  task automatic send_plain(input logic [2:0] act);
    send_action(act, 16'($urandom_range(0, 65535)), rand8(), rand8(), rand8(),
                3'($urandom_range(0, 7)));
  endtask

  task automatic set_px(input logic [15:0] idx, input logic [7:0] r,
                        input logic [7:0] g, input logic [7:0] b);
    send_action(ACT_SET_PIXEL, idx, r, g, b, 3'($urandom_range(0, 7)));
  endtask

  task automatic set_mode(input logic [2:0] md);
    send_action(ACT_SET_MODE, 16'($urandom_range(0, 65535)), rand8(), rand8(), rand8(), md);
  endtask

  task automatic test_reset_state();
    send_plain(ACT_SHOW);
  endtask

  task automatic test_set_pixel();
    set_px(16'd0, 8'hFF, 8'h00, 8'h00);
    set_px(16'(NPIX - 1), 8'h00, 8'hFF, 8'h00);
    set_px(16'd7, 8'h00, 8'h00, 8'hFF);
    set_px(16'(NPIX), 8'hFF, 8'hFF, 8'hFF);
    set_px(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_plain(ACT_SHOW);
  endtask

  task automatic test_set_all();
    send_action(ACT_SET_ALL, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, MODE_TOP);
    send_plain(ACT_SHOW);
    send_action(ACT_SET_ALL, 16'h0000, 8'h5A, 8'hA5, 8'h3C, MODE_OFF);
  endtask

  task automatic test_modes();
    set_mode(MODE_OFF);
    send_plain(ACT_RENDER);
    set_mode(MODE_BREATH);
    send_plain(ACT_RENDER);
    send_plain(ACT_RENDER);
    set_mode(MODE_FLOW);
    send_plain(ACT_RENDER);
    send_plain(ACT_RENDER);
    // ignored modes keep the dot moving
    set_mode(MODE_TOP);
    set_mode(MODE_LIMIT);
    send_plain(ACT_RENDER);
    set_mode(MODE_GRADIENT);
    send_plain(ACT_RENDER);
    set_mode(MODE_COLORFUL);
    send_plain(ACT_RENDER);
    send_plain(ACT_RENDER);
  endtask

  task automatic test_unknown_actions();
    for (logic [3:0] a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++) send_plain(a[2:0]);
    send_plain(ACT_SHOW);
  endtask

  task automatic test_output_holdoff();
    set_mode(MODE_COLORFUL);
    start_holdoff = 1'b1;
    repeat (3) begin
      send_plain(ACT_RENDER);
      send_plain(ACT_SHOW);
    end
  endtask

  task automatic test_long_runs();
    // past the breath peak and a hue wrap
    set_mode(MODE_BREATH);
    repeat (BREATH_HALF + 4) send_plain(ACT_RENDER);
    set_mode(MODE_COLORFUL);
    repeat (40) send_plain(ACT_RENDER);
  endtask

  task automatic test_random();
    int sent;
    int kind;
    int pick;
    logic [2:0] act;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        set_mode(3'($urandom_range(0, 4)));
        sent++;
        repeat ($urandom_range(1, 24)) begin
          pick = $urandom_range(0, 9);
          if (pick < 7) send_plain(ACT_RENDER);
          else if (pick == 7) send_plain(ACT_SHOW);
          else if (pick == 8) set_px(16'($urandom_range(0, NPIX - 1)), rand8(), rand8(), rand8());
          else send_plain(ACT_SET_ALL);
          sent++;
        end
      end else if (kind < 8) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) set_px(16'($urandom_range(0, 65535)), rand8(), rand8(),
                                                rand8());
          else set_px(16'($urandom_range(0, NPIX - 1)), rand8(), rand8(), rand8());
          sent++;
        end
        send_plain(ACT_SHOW);
        sent++;
      end else if (kind == 8) begin
        set_mode(3'($urandom_range(MODE_LIMIT, MODE_TOP)));
        send_plain(ACT_RENDER);
        sent += 2;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          act = 3'($urandom_range(0, 7));
          send_plain(act);
          if (act < ACT_UNUSED_LO) sent++;
        end
      end
    end
  endtask

  // receiver: own stall pattern, plus one long hold-off on request
  always @(negedge clk) begin
    if (start_holdoff) begin
      holdoff_left  = HOLDOFF_LEN;
      start_holdoff = 1'b0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        rx_style   = rx_style_e'($urandom_range(0, 2));
        style_left = $urandom_range(16, 160);
      end
      style_left--;
      case (rx_style)
        RX_STEADY: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            out_ready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_run = $urandom_range(0, 7);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // pixel checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel transaction: led %0d g %h r %h b %h last %b",
                   led_number, out_green, out_red, out_blue, last_pixel);
      end else begin
        want = expected_pixels.pop_front();
        if (led_number !== want.led || out_green !== want.g || out_red !== want.r ||
            out_blue !== want.b || last_pixel !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"pixel mismatch: expected led %0d g %h r %h b %h last %b, ",
                      "got led %0d g %h r %h b %h last %b"},
                     want.led, want.g, want.r, want.b, want.last,
                     led_number, out_green, out_red, out_blue, last_pixel);
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    foreach (led_store[i]) led_store[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_set_pixel();
    test_set_all();
    test_modes();
    test_unknown_actions();
    test_output_holdoff();
    test_long_runs();
    test_random();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4 * NPIX) @(posedge clk);

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/lsae_pkg.sv
rtl/core/lsae_ram.sv
rtl/core/led_strip_animation_engine.sv
verif/tb_top.sv
